@@ rtl/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge.
`define FRIR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition holds on every clock edge.
`define FRIR_ASSERT_ALWAYS(label, cond, msg) \
  `FRIR_ASSERT(label, (cond), msg)

`endif

@@ rtl/frir_pkg.sv @@
package frir_pkg;

  localparam int unsigned StoreDepthDefault = 1024;
  localparam int unsigned FracBitsDefault   = 16;

  localparam int unsigned FuncW    = 1;
  localparam int unsigned WrIdxW   = 10;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned OutIdxW  = 10;
  localparam int unsigned StepW    = 32;
  localparam int unsigned BufLenW  = 11;

  localparam logic [BufLenW-1:0] BufLenReset = 11'd1024;

  localparam logic [FuncW-1:0] FuncLoad    = 1'b0;
  localparam logic [FuncW-1:0] FuncRequest = 1'b1;

  typedef struct packed {
    logic [FuncW-1:0]          func;
    logic [WrIdxW-1:0]         write_index;
    logic signed [SampleW-1:0] sample_value;
    logic [OutIdxW-1:0]        out_index;
    logic [StepW-1:0]          step;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] result_value;
    logic                      beyond_buffer;
  } out_word_t;

endpackage

@@ rtl/frir_ram.sv @@
module frir_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/frir_mul.sv @@
module frir_mul #(
  parameter int unsigned XW = 33,
  parameter int unsigned YW = 17
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [XW-1:0]     x_i,
  input  logic signed [YW-1:0]     y_i,
  output logic signed [XW+YW-1:0]  p_o
);

  logic signed [XW+YW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= x_i * y_i;
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/fractional_index_resampler_unit.sv @@
// Channel | Direction | Handshake                 | Word
// in      | input     | in_valid_i / in_stall_o   | in_word_i  (frir_pkg::in_word_t)
// out     | output    | out_valid_o / out_stall_i | out_word_o (frir_pkg::out_word_t)
// cfg     | input     | cfg_we_i                  | cfg_wdata_i (buf_len)
//
// A load word gives no result; the next word may follow at once.
// A request word steps through StMul, StCheck, StRdB, StDiff, StSum and StDone (beyond the
// buffer from StCheck to StDone); the next word is taken once StDone is left. The steps are
// set by the one shared multiplier used twice and the single read port of the sample store.
// The input is stalled while a request is in work, including while its word waits for the
// output register; a pending output word alone does not stall it.
// Reset clears control and sets buf_len to 1024; the sample store is not cleared.
`include "assert_macros.svh"

module fractional_index_resampler_unit #(
  parameter int unsigned STORE_DEPTH = frir_pkg::StoreDepthDefault,
  parameter int unsigned FRAC_BITS   = frir_pkg::FracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  frir_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output frir_pkg::out_word_t               out_word_o,
  input  logic                              cfg_we_i,
  input  logic [frir_pkg::BufLenW-1:0]      cfg_wdata_i
);

  localparam int unsigned AddrW  = $clog2(STORE_DEPTH);
  localparam int unsigned XW     = frir_pkg::StepW + 1;
  localparam int unsigned YW     = (FRAC_BITS + 1 > frir_pkg::OutIdxW + 1) ?
                                   FRAC_BITS + 1 : frir_pkg::OutIdxW + 1;
  localparam int unsigned ProdW  = XW + YW;
  localparam int unsigned PosW   = frir_pkg::OutIdxW + frir_pkg::StepW;
  localparam int unsigned WholeW = PosW - FRAC_BITS;
  localparam int unsigned CmpW   = WholeW + 1;
  localparam int unsigned DiffW  = frir_pkg::SampleW + 1;
  localparam int unsigned NumW   = frir_pkg::SampleW + FRAC_BITS + 2;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StCheck,
    StRdB,
    StDiff,
    StSum,
    StDone
  } state_e;

  state_e                            state_q;
  logic [frir_pkg::BufLenW-1:0]      buf_len_q;
  logic [frir_pkg::OutIdxW-1:0]      idx_q;
  logic [frir_pkg::StepW-1:0]        step_q;
  logic signed [frir_pkg::SampleW-1:0] a_q;
  frir_pkg::out_word_t               res_q;
  frir_pkg::out_word_t               out_word_q;
  logic                              out_valid_q;

  logic                              accept;
  logic                              ram_we;
  logic [AddrW-1:0]                  ram_waddr;
  logic [AddrW-1:0]                  ram_raddr;
  logic [frir_pkg::SampleW-1:0]      ram_rdata;
  logic                              mul_en;
  logic signed [XW-1:0]              mul_x;
  logic signed [YW-1:0]              mul_y;
  logic signed [ProdW-1:0]           mul_p;
  logic [PosW-1:0]                   pos;
  logic [WholeW-1:0]                 whole;
  logic [FRAC_BITS-1:0]              frac;
  logic [CmpW-1:0]                   len_eff;
  logic                              in_range;
  logic signed [DiffW-1:0]           diff;
  logic signed [NumW-1:0]            num;
  logic signed [NumW-1:0]            quo;
  logic                              out_free;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign ram_we    = accept && (in_word_i.func == frir_pkg::FuncLoad) &&
                     (32'(in_word_i.write_index) < 32'(STORE_DEPTH));
  assign ram_waddr = AddrW'(in_word_i.write_index);

  assign pos   = mul_p[PosW-1:0];
  assign whole = pos[PosW-1:FRAC_BITS];
  assign frac  = pos[FRAC_BITS-1:0];

  always_comb begin
    if (32'(buf_len_q) > 32'(STORE_DEPTH)) begin
      len_eff = CmpW'(STORE_DEPTH);
    end else begin
      len_eff = CmpW'(buf_len_q);
    end
  end

  assign in_range  = (CmpW'(whole) + CmpW'(1)) < len_eff;
  assign ram_raddr = (state_q == StRdB) ? (whole[AddrW-1:0] + AddrW'(1)) : whole[AddrW-1:0];

  assign diff = DiffW'($signed(ram_rdata)) - DiffW'(a_q);

  always_comb begin
    mul_en = 1'b0;
    mul_x  = $signed(XW'(step_q));
    mul_y  = $signed(YW'(idx_q));
    unique case (state_q)
      StMul: begin
        mul_en = 1'b1;
      end
      StDiff: begin
        mul_en = 1'b1;
        mul_x  = XW'(diff);
        mul_y  = $signed(YW'(frac));
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign num = NumW'($signed({a_q, FRAC_BITS'(0)})) + NumW'(mul_p);

  always_comb begin
    quo = num >>> FRAC_BITS;
    if (num[NumW-1] && (num[FRAC_BITS-1:0] != '0)) begin
      quo = quo + NumW'(1);
    end
  end

  frir_ram #(
    .Width (frir_pkg::SampleW),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_word_i.sample_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  frir_mul #(
    .XW (XW),
    .YW (YW)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .x_i   (mul_x),
    .y_i   (mul_y),
    .p_o   (mul_p)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= frir_pkg::BufLenReset;
    end else if (cfg_we_i) begin
      buf_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (accept && (in_word_i.func == frir_pkg::FuncRequest)) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          state_q <= StCheck;
        end
        StCheck: begin
          if (in_range) begin
            state_q <= StRdB;
          end else begin
            state_q <= StDone;
          end
        end
        StRdB: begin
          state_q <= StDiff;
        end
        StDiff: begin
          state_q <= StSum;
        end
        StSum: begin
          state_q <= StDone;
        end
        StDone: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q  <= in_word_i.out_index;
      step_q <= in_word_i.step;
    end
    if (state_q == StRdB) begin
      a_q <= $signed(ram_rdata);
    end
    if (state_q == StCheck) begin
      res_q.result_value  <= '0;
      res_q.beyond_buffer <= !in_range;
    end
    if (state_q == StSum) begin
      res_q.result_value  <= quo[frir_pkg::SampleW-1:0];
      res_q.beyond_buffer <= 1'b0;
    end
    if ((state_q == StDone) && out_free) begin
      out_word_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `FRIR_ASSERT(a_out_from_done, $rose(out_valid_o) |-> $past(state_q == StDone),
               "output word raised without a finished request")
  `FRIR_ASSERT(a_beyond_zero, (out_valid_o && out_word_o.beyond_buffer) |->
               (out_word_o.result_value == '0), "beyond-buffer word carries a value")
  `FRIR_ASSERT_ALWAYS(a_write_idle, !ram_we || (state_q == StIdle),
                      "sample store written while a request is in work")
  `FRIR_ASSERT(a_check_next, (state_q == StCheck) |=>
               ((state_q == StRdB) || (state_q == StDone)), "bad step after range check")

endmodule

@@ sim/resample_checker.sv @@
module resample_checker import frir_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_word_t           in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_word_t          out_word_i,
  input  logic               cfg_we_i,
  input  logic [BufLenW-1:0] cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int unsigned Depth = StoreDepthDefault;
  localparam int unsigned Frac  = FracBitsDefault;

  logic signed [SampleW-1:0] sample_copy [Depth];
  logic [BufLenW-1:0]        length_copy;
  out_word_t                 expected_words [$];
  out_word_t                 oldest;
  int                        fails = 0;

  function automatic out_word_t interp_sample(in_word_t w);
    longint unsigned oi;
    longint unsigned pos;
    longint unsigned whole;
    longint unsigned frac;
    longint unsigned len;
    longint          a;
    longint          b;
    longint          scale;
    longint          num;
    longint          quot;
    out_word_t       r;
    oi = w.out_index;
    pos = oi * w.step;
    whole = pos >> Frac;
    frac = pos & ((64'd1 << Frac) - 64'd1);
    len = length_copy;
    if (len > Depth) len = Depth;
    r.result_value = '0;
    r.beyond_buffer = 1'b1;
    if (len >= 2 && whole < len - 1) begin
      a = sample_copy[whole];
      b = sample_copy[whole + 1];
      scale = longint'(1) << Frac;
      num = a * scale + longint'(frac) * (b - a);
      quot = num / scale;
      r.result_value = quot[SampleW-1:0];
      r.beyond_buffer = 1'b0;
    end
    return r;
  endfunction

  assign fail_count_o = fails;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_copy = BufLenReset;
      expected_words.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) length_copy = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result word: result_value %0d beyond_buffer %0b",
                 out_word_i.result_value, out_word_i.beyond_buffer);
          fails++;
        end else begin
          oldest = expected_words.pop_front();
          if (out_word_i.result_value !== oldest.result_value) begin
            $error("result_value expected %0d actual %0d",
                   oldest.result_value, out_word_i.result_value);
            fails++;
          end
          if (out_word_i.beyond_buffer !== oldest.beyond_buffer) begin
            $error("beyond_buffer expected %0b actual %0b",
                   oldest.beyond_buffer, out_word_i.beyond_buffer);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_word_i.func == FuncLoad) begin
          sample_copy[in_word_i.write_index] = in_word_i.sample_value;
        end else begin
          expected_words.push_back(interp_sample(in_word_i));
        end
      end
      pending_o = expected_words.size();
    end
  end

endmodule

@@ sim/tb.sv @@
module tb;
  import frir_pkg::*;

  localparam int Limit = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_word;
  logic               cfg_we = 1'b0;
  logic [BufLenW-1:0] cfg_wdata = '0;

  int  fail_count;
  int  pending;
  int  cycles = 0;
  int  stall_left = 0;
  int  words_sent = 0;
  int  phase_start = 0;
  int  buf_len = 1024;
  bit  no_idle = 1'b0;
  bit  out_took = 1'b0;
  bit  loaded [StoreDepthDefault];
  int  lengths [10] = '{1024, 2, 2047, 3, 0, 700, 1023, 1, 1025, 0};

  fractional_index_resampler_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  resample_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("[fractional_index_resampler_unit] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_took <= out_valid && !out_stall;
  end

  always @(negedge clk) begin
    int left;
    left = out_took ? (no_idle ? 0 : $urandom_range(0, 4)) : stall_left;
    if (left > 0) begin
      out_stall <= 1'b1;
      stall_left <= out_valid ? left - 1 : left;
    end else begin
      out_stall <= 1'b0;
      stall_left <= left;
    end
  end

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic put_sample(input int unsigned idx, input logic [SampleW-1:0] val);
    in_word_t w;
    w.func = FuncLoad;
    w.write_index = idx[WrIdxW-1:0];
    w.sample_value = val;
    w.out_index = OutIdxW'($urandom);
    w.step = $urandom;
    loaded[idx] = 1'b1;
    send_word(w);
  endtask

  task automatic ask(input logic [OutIdxW-1:0] oi, input logic [StepW-1:0] st);
    longint unsigned pos;
    longint unsigned whole;
    int              len_eff;
    in_word_t        w;
    pos = oi;
    pos = pos * st;
    whole = pos >> FracBitsDefault;
    len_eff = (buf_len > 1024) ? 1024 : buf_len;
    if (len_eff >= 2 && whole < len_eff - 1) begin
      if (!loaded[whole]) put_sample(32'(whole), pick_sample());
      if (!loaded[whole + 1]) put_sample(32'(whole + 1), pick_sample());
    end
    w.func = FuncRequest;
    w.write_index = WrIdxW'($urandom);
    w.sample_value = SampleW'($urandom);
    w.out_index = oi;
    w.step = st;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_length(input int len);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= len[BufLenW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    buf_len = len;
  endtask

  task automatic random_request();
    int              len_eff;
    int              base;
    logic [9:0]      oi;
    longint unsigned pos;
    len_eff = (buf_len > 1024) ? 1024 : buf_len;
    base = (len_eff > 0) ? len_eff - 1 : 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        oi = OutIdxW'($urandom_range(1, 1023));
        pos = (len_eff >= 2) ? $urandom_range(0, len_eff - 2) : 0;
        pos = (pos << FracBitsDefault) | $urandom_range(0, 65535);
        ask(oi, StepW'(pos / oi));
      end
      6: ask(10'd0, $urandom);
      7: begin
        pos = base + $urandom_range(0, 2);
        pos = (pos << FracBitsDefault) | $urandom_range(0, 65535);
        ask(10'd1, StepW'(pos));
      end
      default: ask(OutIdxW'($urandom), $urandom);
    endcase
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    put_sample(0, 16'h7FFF);
    put_sample(1, 16'h8000);
    put_sample(2, 16'h0000);
    put_sample(3, 16'hFFFF);
    put_sample(1022, 16'h7FFF);
    put_sample(1023, 16'h8000);
    ask(10'd0, 32'h0000_0000);
    ask(10'd1, 32'h0000_8000);
    ask(10'd1, 32'h0000_FFFF);
    ask(10'd1023, 32'h0000_0001);
    ask(10'd1, 32'h0002_4000);
    ask(10'd1, {16'd1022, 16'hFFFF});
    ask(10'd1, {16'd1023, 16'h0000});
    ask(10'd1023, 32'hFFFF_FFFF);
    set_length(2);
    ask(10'd1, 32'h0000_C000);
    ask(10'd1, 32'h0001_0000);
    set_length(0);
    ask(10'd0, 32'h0000_0000);
    set_length(1);
    ask(10'd0, 32'h0000_0001);
    set_length(2047);
    ask(10'd1, {16'd1022, 16'h1234});
    ask(10'd1, {16'd1023, 16'h0000});

    for (int p = 0; p < 10; p++) begin
      set_length((p == 9) ? $urandom_range(2, 2047) : lengths[p]);
      no_idle = (p % 4 == 3);
      phase_start = words_sent;
      while (words_sent - phase_start < 83) begin
        if ($urandom_range(0, 99) < 30) begin
          put_sample(($urandom_range(0, 1) && buf_len > 0 && buf_len <= 1024) ?
                     $urandom_range(0, buf_len - 1) : $urandom_range(0, 1023),
                     pick_sample());
        end else begin
          random_request();
        end
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[fractional_index_resampler_unit] OK");
    end else begin
      $display("[fractional_index_resampler_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/frir_pkg.sv
rtl/frir_ram.sv
rtl/frir_mul.sv
rtl/fractional_index_resampler_unit.sv
sim/resample_checker.sv
sim/tb.sv
